// File: hw/rtl/helix_point_generator_assert.svh
// Assertion macros for the helix point generator checker.
// Expects i_clk and i_rst_n in the scope where the macros are used.
`ifndef HELIX_POINT_GENERATOR_ASSERT_SVH
`define HELIX_POINT_GENERATOR_ASSERT_SVH

// same-cycle implication, clocked on i_clk, off while in reset
`define HPG_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("helix point generator: same-cycle check failed");

// next-cycle implication
`define HPG_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("helix point generator: next-cycle check failed");

`endif

// File: hw/rtl/hpg_pkg.sv
// Package for the helix point generator: sequencer states, angle constants,
// Taylor divisor and reciprocal tables. No dependencies.
`default_nettype none

package hpg_pkg;

    // defaults for the top level parameters
    localparam int unsigned MAX_POINTS_DEF     = 64;
    localparam int unsigned TRIG_FRAC_BITS_DEF = 16;

    // angle step between points, whole degrees
    localparam int unsigned ANGLE_STEP_DEG = 10;
    localparam logic [15:0] STEP_CD        = 16'(ANGLE_STEP_DEG * 100);
    localparam logic [10:0] STEP_SWEPT     = 11'(ANGLE_STEP_DEG);

    localparam logic [15:0] FULL_TURN = 16'd36000;
    localparam logic [15:0] QUARTER   = 16'd9000;
    localparam logic [13:0] EIGHTH    = 14'd4500;
    localparam logic [9:0]  TOTAL_MAX = 10'd640;

    localparam logic [1:0] QUAD_I   = 2'd0;
    localparam logic [1:0] QUAD_II  = 2'd1;
    localparam logic [1:0] QUAD_III = 2'd2;
    localparam logic [1:0] QUAD_IV  = 2'd3;

    // pi in Q30 split as PI_A * 18000 + PI_B, so that
    // round(r * pi / 18000) = r * PI_A + (r * PI_B + 9000) / 18000
    localparam logic [31:0] PI_A     = 32'd187403;
    localparam logic [31:0] PI_B     = 32'd5426;
    localparam logic [29:0] PI_RND   = 30'd9000;
    localparam logic [30:0] ONE_Q30  = 31'h4000_0000;

    // divisor table: sine terms, cosine terms, then the angle scaling
    localparam int unsigned DIV_N = 10;
    localparam logic [3:0] SIN_FIRST = 4'd0;
    localparam logic [3:0] SIN_LAST  = 4'd3;
    localparam logic [3:0] COS_FIRST = 4'd4;
    localparam logic [3:0] COS_LAST  = 4'd8;
    localparam logic [3:0] DIV_X_IDX = 4'd9;

    localparam logic [14:0] DIV_TAB [DIV_N] = '{
        15'd72, 15'd42, 15'd20, 15'd6,
        15'd90, 15'd56, 15'd30, 15'd12, 15'd2,
        15'd18000
    };

    // floor(2^32 / divisor); quotient is then exact or one short
    localparam logic [31:0] RECIP_TAB [DIV_N] = '{
        32'd59652323, 32'd102261126, 32'd214748364, 32'd715827882,
        32'd47721858, 32'd76695844, 32'd143165576, 32'd357913941, 32'd2147483648,
        32'd238609
    };

    typedef enum logic [4:0] {
        S_IDLE,
        S_FOLD,
        S_XB,
        S_XV,
        S_XA,
        S_XQ,
        S_X2M,
        S_X2,
        S_TERM,
        S_TV,
        S_DMUL,
        S_DBACK,
        S_DFIX,
        S_TUPD,
        S_SIN,
        S_SINR,
        S_MPX,
        S_MPY,
        S_MPZ,
        S_EMIT
    } t_state;

endpackage

`default_nettype wire

// File: hw/rtl/helix_point_generator.sv
// Helix point generator top level: sequencer around one shared 32x32 multiplier.
// Depends on hpg_pkg.
`default_nettype none

// A request is taken when start is high and busy is low. It gives
// N = ceil(min(total_angle, 640) / 10) points, at most MAX_POINTS, and a zero
// total gives none and leaves busy low. Busy stays high until the final point
// is out. The single multiplier forms the angle in radians, the nine Taylor
// terms of sine and cosine, the reciprocal multiply and back-multiply of every
// division by a constant, and the x, y and z scalings, one product per cycle.
// Each point is shown for exactly one cycle with o_strobe high, the final
// one with o_last_point; the receiver cannot stall, so it must take every word.
module helix_point_generator #(
    parameter int unsigned MAX_POINTS     = hpg_pkg::MAX_POINTS_DEF,
    parameter int unsigned TRIG_FRAC_BITS = hpg_pkg::TRIG_FRAC_BITS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic signed [30:0] i_center_x,
    input  wire logic signed [30:0] i_center_y,
    input  wire logic signed [30:0] i_center_z,
    input  wire logic        [29:0] i_radius,
    input  wire logic        [15:0] i_start_angle,
    input  wire logic signed [23:0] i_height_per_degree,
    input  wire logic        [9:0]  i_total_angle,
    input  wire logic               i_counter_clockwise,
    output logic                    o_strobe,
    output logic signed      [31:0] o_point_x,
    output logic signed      [31:0] o_point_y,
    output logic signed      [31:0] o_point_z,
    output logic                    o_last_point
);

    localparam int unsigned KW = $clog2(MAX_POINTS + 1);
    localparam int unsigned MW = TRIG_FRAC_BITS + 1;
    localparam int unsigned SH = 30 - TRIG_FRAC_BITS;

    hpg_pkg::t_state r_state, n_state;

    // request
    logic [30:0] r_cx, r_cy, r_cz;
    logic [29:0] r_radius;
    logic [23:0] r_hmag;
    logic        r_hneg;
    logic        r_ccw;
    logic [9:0]  r_total;

    // per point
    logic [15:0]    r_angle;
    logic [KW-1:0]  r_k;
    logic [9:0]     r_swept;
    logic [1:0]     r_quad;
    logic [12:0]    r_oct;
    logic           r_swap;
    logic [29:0]    r_x, r_x2, r_v, r_q;
    logic [30:0]    r_t;
    logic [3:0]     r_term, r_didx;
    logic [MW-1:0]  r_sin, r_cos;
    logic [63:0]    r_prod;

    logic [31:0] r_point_x, r_point_y, r_point_z;
    logic        r_strobe, r_last;

    // shared multiplier
    logic [31:0] mul_a, mul_b;
    logic [63:0] n_prod;

    // request decode
    logic [9:0]  tot_sat;
    logic [15:0] start_red;

    // angle fold
    logic [1:0]  f_quad;
    logic [13:0] f_rem;
    logic [12:0] f_oct;
    logic        f_swap;

    // trig mapping and scaling
    logic [MW-1:0] s0, c0, sm, cm;
    logic          sn, cn;
    logic [63:0]   sc_sum;
    logic [30:0]   sc_mag;
    logic [32:0]   sc_x, sc_y, sc_z;
    logic [25:0]   z_mag;

    // division fix-up
    logic [29:0] d_rem;
    logic [14:0] d_div;

    // step advance
    logic [10:0] sw_next;
    logic        last_pt;
    logic [16:0] ang_up;
    logic [15:0] ang_next;
    logic [30:0] t_new;

    function automatic logic [MW-1:0] frac_round(input logic [30:0] v);
        logic [31:0] s;
        s = {1'b0, v} + (32'd1 << (SH - 1));
        return s[SH +: MW];
    endfunction

    assign busy         = (r_state != hpg_pkg::S_IDLE);
    assign o_strobe     = r_strobe;
    assign o_point_x    = r_point_x;
    assign o_point_y    = r_point_y;
    assign o_point_z    = r_point_z;
    assign o_last_point = r_last;

    assign n_prod = {32'b0, mul_a} * {32'b0, mul_b};

    assign tot_sat   = (i_total_angle > hpg_pkg::TOTAL_MAX) ? hpg_pkg::TOTAL_MAX
                                                            : i_total_angle;
    assign start_red = (i_start_angle >= hpg_pkg::FULL_TURN)
                     ? i_start_angle - hpg_pkg::FULL_TURN : i_start_angle;

    always_comb begin
        if (r_angle >= 16'(3 * hpg_pkg::QUARTER)) begin
            f_quad = hpg_pkg::QUAD_IV;
            f_rem  = 14'(r_angle - 16'(3 * hpg_pkg::QUARTER));
        end else if (r_angle >= 16'(2 * hpg_pkg::QUARTER)) begin
            f_quad = hpg_pkg::QUAD_III;
            f_rem  = 14'(r_angle - 16'(2 * hpg_pkg::QUARTER));
        end else if (r_angle >= hpg_pkg::QUARTER) begin
            f_quad = hpg_pkg::QUAD_II;
            f_rem  = 14'(r_angle - hpg_pkg::QUARTER);
        end else begin
            f_quad = hpg_pkg::QUAD_I;
            f_rem  = r_angle[13:0];
        end
        f_swap = (f_rem > hpg_pkg::EIGHTH);
        f_oct  = f_swap ? 13'(14'(hpg_pkg::QUARTER) - f_rem) : f_rem[12:0];
    end

    // past the octant the sine and cosine series swap roles
    assign s0 = r_swap ? r_cos : r_sin;
    assign c0 = r_swap ? r_sin : r_cos;

    always_comb begin
        case (r_quad)
            hpg_pkg::QUAD_I: begin
                sm = s0; sn = 1'b0; cm = c0; cn = 1'b0;
            end
            hpg_pkg::QUAD_II: begin
                sm = c0; sn = 1'b0; cm = s0; cn = 1'b1;
            end
            hpg_pkg::QUAD_III: begin
                sm = s0; sn = 1'b1; cm = c0; cn = 1'b1;
            end
            default: begin
                sm = c0; sn = 1'b1; cm = s0; cn = 1'b0;
            end
        endcase
    end

    // radius * |trig| rounded half up, then signed onto the centre
    assign sc_sum = r_prod + (64'd1 << (TRIG_FRAC_BITS - 1));
    assign sc_mag = sc_sum[TRIG_FRAC_BITS +: 31];
    assign sc_x   = cn ? {{2{r_cx[30]}}, r_cx} - {2'b0, sc_mag}
                       : {{2{r_cx[30]}}, r_cx} + {2'b0, sc_mag};
    assign sc_y   = sn ? {{2{r_cy[30]}}, r_cy} - {2'b0, sc_mag}
                       : {{2{r_cy[30]}}, r_cy} + {2'b0, sc_mag};
    // rise truncates toward zero: shift the magnitude, then apply the sign
    assign z_mag  = r_prod[33:8];
    assign sc_z   = r_hneg ? {{2{r_cz[30]}}, r_cz} - {7'b0, z_mag}
                           : {{2{r_cz[30]}}, r_cz} + {7'b0, z_mag};

    assign d_div = hpg_pkg::DIV_TAB[r_didx];
    assign d_rem = r_v - r_prod[29:0];
    assign t_new = hpg_pkg::ONE_Q30 - {1'b0, r_q};

    assign sw_next = {1'b0, r_swept} + hpg_pkg::STEP_SWEPT;
    assign last_pt = (sw_next >= {1'b0, r_total}) || (r_k == KW'(MAX_POINTS - 1));
    assign ang_up  = {1'b0, r_angle} + {1'b0, hpg_pkg::STEP_CD};

    always_comb begin
        if (r_ccw) begin
            ang_next = (ang_up >= {1'b0, hpg_pkg::FULL_TURN})
                     ? 16'(ang_up - {1'b0, hpg_pkg::FULL_TURN}) : ang_up[15:0];
        end else if (r_angle >= hpg_pkg::STEP_CD) begin
            ang_next = r_angle - hpg_pkg::STEP_CD;
        end else begin
            ang_next = r_angle + hpg_pkg::FULL_TURN - hpg_pkg::STEP_CD;
        end
    end

    // sequencer: next state and multiplier operands
    always_comb begin
        n_state = r_state;
        mul_a   = '0;
        mul_b   = '0;
        case (r_state)
            hpg_pkg::S_IDLE: begin
                if (start && (tot_sat != '0)) n_state = hpg_pkg::S_FOLD;
            end
            hpg_pkg::S_FOLD: n_state = hpg_pkg::S_XB;
            hpg_pkg::S_XB: begin
                mul_a   = {19'b0, r_oct};
                mul_b   = hpg_pkg::PI_B;
                n_state = hpg_pkg::S_XV;
            end
            hpg_pkg::S_XV: begin
                mul_a   = {19'b0, r_oct};
                mul_b   = hpg_pkg::PI_A;
                n_state = hpg_pkg::S_XA;
            end
            hpg_pkg::S_XA: n_state = hpg_pkg::S_DMUL;
            hpg_pkg::S_XQ: n_state = hpg_pkg::S_X2M;
            hpg_pkg::S_X2M: begin
                mul_a   = {2'b0, r_x};
                mul_b   = {2'b0, r_x};
                n_state = hpg_pkg::S_X2;
            end
            hpg_pkg::S_X2: n_state = hpg_pkg::S_TERM;
            hpg_pkg::S_TERM: begin
                if ((r_term == hpg_pkg::SIN_FIRST) || (r_term == hpg_pkg::COS_FIRST)) begin
                    n_state = hpg_pkg::S_DMUL;
                end else begin
                    mul_a   = {2'b0, r_x2};
                    mul_b   = {1'b0, r_t};
                    n_state = hpg_pkg::S_TV;
                end
            end
            hpg_pkg::S_TV: n_state = hpg_pkg::S_DMUL;
            hpg_pkg::S_DMUL: begin
                mul_a   = {2'b0, r_v};
                mul_b   = hpg_pkg::RECIP_TAB[r_didx];
                n_state = hpg_pkg::S_DBACK;
            end
            hpg_pkg::S_DBACK: begin
                mul_a   = r_prod[63:32];
                mul_b   = {17'b0, d_div};
                n_state = hpg_pkg::S_DFIX;
            end
            hpg_pkg::S_DFIX: begin
                n_state = (r_didx == hpg_pkg::DIV_X_IDX) ? hpg_pkg::S_XQ : hpg_pkg::S_TUPD;
            end
            hpg_pkg::S_TUPD: begin
                if (r_term == hpg_pkg::SIN_LAST) begin
                    n_state = hpg_pkg::S_SIN;
                end else if (r_term == hpg_pkg::COS_LAST) begin
                    n_state = hpg_pkg::S_MPX;
                end else begin
                    n_state = hpg_pkg::S_TERM;
                end
            end
            hpg_pkg::S_SIN: begin
                mul_a   = {2'b0, r_x};
                mul_b   = {1'b0, r_t};
                n_state = hpg_pkg::S_SINR;
            end
            hpg_pkg::S_SINR: n_state = hpg_pkg::S_TERM;
            hpg_pkg::S_MPX: begin
                mul_a   = {2'b0, r_radius};
                mul_b   = 32'(cm);
                n_state = hpg_pkg::S_MPY;
            end
            hpg_pkg::S_MPY: begin
                mul_a   = {2'b0, r_radius};
                mul_b   = 32'(sm);
                n_state = hpg_pkg::S_MPZ;
            end
            hpg_pkg::S_MPZ: begin
                mul_a   = {8'b0, r_hmag};
                mul_b   = {22'b0, r_swept};
                n_state = hpg_pkg::S_EMIT;
            end
            hpg_pkg::S_EMIT: n_state = last_pt ? hpg_pkg::S_IDLE : hpg_pkg::S_FOLD;
            default: n_state = hpg_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= hpg_pkg::S_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= (r_state == hpg_pkg::S_EMIT);
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
        case (r_state)
            hpg_pkg::S_IDLE: begin
                if (start) begin
                    r_cx     <= i_center_x;
                    r_cy     <= i_center_y;
                    r_cz     <= i_center_z;
                    r_radius <= i_radius;
                    r_hneg   <= i_height_per_degree[23];
                    r_hmag   <= i_height_per_degree[23] ? (~i_height_per_degree + 24'd1)
                                                        : i_height_per_degree;
                    r_ccw    <= i_counter_clockwise;
                    r_total  <= tot_sat;
                    r_angle  <= start_red;
                    r_k      <= '0;
                    r_swept  <= '0;
                end
            end
            hpg_pkg::S_FOLD: begin
                r_quad <= f_quad;
                r_oct  <= f_oct;
                r_swap <= f_swap;
            end
            hpg_pkg::S_XV: r_v <= r_prod[29:0] + hpg_pkg::PI_RND;
            hpg_pkg::S_XA: begin
                r_x    <= r_prod[29:0];
                r_didx <= hpg_pkg::DIV_X_IDX;
            end
            hpg_pkg::S_XQ: r_x <= r_x + r_q;
            hpg_pkg::S_X2: begin
                r_x2   <= r_prod[59:30];
                r_term <= hpg_pkg::SIN_FIRST;
            end
            hpg_pkg::S_TERM: begin
                if ((r_term == hpg_pkg::SIN_FIRST) || (r_term == hpg_pkg::COS_FIRST)) begin
                    r_v    <= r_x2;
                    r_didx <= r_term;
                end
            end
            hpg_pkg::S_TV: begin
                r_v    <= r_prod[59:30];
                r_didx <= r_term;
            end
            hpg_pkg::S_DBACK: r_q <= r_prod[61:32];
            hpg_pkg::S_DFIX: begin
                // reciprocal estimate may be one short
                if (d_rem >= {15'b0, d_div}) r_q <= r_q + 30'd1;
            end
            hpg_pkg::S_TUPD: begin
                r_t    <= t_new;
                r_term <= r_term + 4'd1;
                if (r_term == hpg_pkg::COS_LAST) r_cos <= frac_round(t_new);
            end
            hpg_pkg::S_SINR: r_sin <= frac_round(r_prod[60:30]);
            hpg_pkg::S_MPY: r_point_x <= sc_x[31:0];
            hpg_pkg::S_MPZ: r_point_y <= sc_y[31:0];
            hpg_pkg::S_EMIT: begin
                r_point_z <= sc_z[31:0];
                r_last    <= last_pt;
                r_angle   <= ang_next;
                r_k       <= r_k + KW'(1);
                r_swept   <= sw_next[9:0];
            end
            default: begin
            end
        endcase
    end

endmodule

`default_nettype wire

// File: hw/rtl/hpg_checker.sv
// Port-level checker for the helix point generator, bound to the top level.
// Depends on helix_point_generator_assert.svh.
`default_nettype none

`include "helix_point_generator_assert.svh"

module hpg_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       start,
    input wire logic       busy,
    input wire logic [9:0] i_total_angle,
    input wire logic       o_strobe,
    input wire logic       o_last_point
);

    // a word only ever follows a cycle of work
    `HPG_ASSERT_IMPL(a_strobe_after_busy, o_strobe, $past(busy))
    // words are at least one point apart
    `HPG_ASSERT_NEXT(a_no_back_to_back, o_strobe, !o_strobe)
    // the final word ends the request, any other word has more to follow
    `HPG_ASSERT_IMPL(a_last_ends_busy, o_strobe, (o_last_point == !busy))
    // a nonzero total starts work, a zero total leaves the block free
    `HPG_ASSERT_NEXT(a_accept_busy, start && !busy && (i_total_angle != 10'd0), busy)
    `HPG_ASSERT_NEXT(a_zero_idle, start && !busy && (i_total_angle == 10'd0), !busy)

endmodule

bind helix_point_generator hpg_checker u_hpg_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .start         (start),
    .busy          (busy),
    .i_total_angle (i_total_angle),
    .o_strobe      (o_strobe),
    .o_last_point  (o_last_point)
);

`default_nettype wire

// File: tb/helix_point_generator_tb.sv
// Self-checking bench for helix_point_generator: directed and random helix requests,
// each point word checked against a bit-true predictor held in a small class.
// Depends on hpg_pkg and the helix_point_generator RTL.
`default_nettype none

module helix_point_generator_tb;

    localparam int unsigned     MAX_PTS        = hpg_pkg::MAX_POINTS_DEF;
    localparam int unsigned     FRAC_BITS      = hpg_pkg::TRIG_FRAC_BITS_DEF;
    localparam longint unsigned PI_Q30         = 64'd3373259426;
    localparam longint unsigned UNIT_Q30       = 64'd1 << 30;
    localparam int unsigned     RANDOM_ITEMS   = 312;
    localparam int unsigned     CALM_TAIL      = 60;
    localparam int unsigned     WATCHDOG_LIMIT = 3000;
    localparam int unsigned     DRAIN_CYCLES   = 200;

    typedef struct {
        logic signed [30:0] cx;
        logic signed [30:0] cy;
        logic signed [30:0] cz;
        logic        [29:0] radius;
        logic        [15:0] start_angle;
        logic signed [23:0] hpd;
        logic        [9:0]  total;
        logic               ccw;
    } t_helix_req;

    typedef struct {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic        last;
    } t_point;

    class t_helix_tracker;
        t_point      due_points[$];
        int unsigned faults;
        logic [15:0] angle_now;
        logic [6:0]  points_done;

        function new();
            faults      = 0;
            angle_now   = '0;
            points_done = '0;
        endfunction

        function longint unsigned taylor_step(longint unsigned x2, longint unsigned t,
                                              longint unsigned div);
            return UNIT_Q30 - ((x2 * t) >> 30) / div;
        endfunction

        // sine and cosine of r in [0, 4500] centidegrees, unsigned Q30
        function void octant_trig(input int unsigned r, output longint unsigned s,
                                  output longint unsigned c);
            longint unsigned x, x2, t;
            x  = (64'(r) * PI_Q30 + 64'd9000) / 64'd18000;
            x2 = (x * x) >> 30;
            t  = UNIT_Q30 - x2 / 72;
            t  = taylor_step(x2, t, 42);
            t  = taylor_step(x2, t, 20);
            t  = taylor_step(x2, t, 6);
            s  = (x * t) >> 30;
            t  = UNIT_Q30 - x2 / 90;
            t  = taylor_step(x2, t, 56);
            t  = taylor_step(x2, t, 30);
            t  = taylor_step(x2, t, 12);
            c  = taylor_step(x2, t, 2);
        endfunction

        function longint unsigned q30_to_frac(longint unsigned v);
            return (v + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
        endfunction

        function longint scaled(logic [29:0] radius, longint unsigned mag, bit neg);
            longint unsigned p;
            p = (64'(radius) * mag + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
            return neg ? -longint'(p) : longint'(p);
        endfunction

        // expands one accepted request into its point words
        function void note_request(t_helix_req rq);
            int unsigned     total, npts, ang, quad, rem;
            longint unsigned s0, c0, smag, cmag;
            bit              sneg, cneg;
            longint          cx, cy, cz, swept;
            t_point          pt;
            cx    = rq.cx;
            cy    = rq.cy;
            cz    = rq.cz;
            total = (rq.total > hpg_pkg::TOTAL_MAX) ? hpg_pkg::TOTAL_MAX : rq.total;
            npts  = (total + hpg_pkg::ANGLE_STEP_DEG - 1) / hpg_pkg::ANGLE_STEP_DEG;
            if (npts > MAX_PTS) npts = MAX_PTS;
            angle_now   = 16'(rq.start_angle % hpg_pkg::FULL_TURN);
            points_done = '0;
            for (int unsigned k = 0; k < npts; k++) begin
                ang  = angle_now;
                quad = ang / hpg_pkg::QUARTER;
                rem  = ang % hpg_pkg::QUARTER;
                if (rem <= hpg_pkg::EIGHTH) octant_trig(rem, s0, c0);
                else octant_trig(hpg_pkg::QUARTER - rem, c0, s0);
                s0 = q30_to_frac(s0);
                c0 = q30_to_frac(c0);
                case (2'(quad))
                    hpg_pkg::QUAD_I: begin
                        smag = s0; sneg = 1'b0; cmag = c0; cneg = 1'b0;
                    end
                    hpg_pkg::QUAD_II: begin
                        smag = c0; sneg = 1'b0; cmag = s0; cneg = 1'b1;
                    end
                    hpg_pkg::QUAD_III: begin
                        smag = s0; sneg = 1'b1; cmag = c0; cneg = 1'b1;
                    end
                    default: begin
                        smag = c0; sneg = 1'b1; cmag = s0; cneg = 1'b0;
                    end
                endcase
                swept   = longint'(k * hpg_pkg::ANGLE_STEP_DEG);
                pt.x    = 32'(cx + scaled(rq.radius, cmag, cneg));
                pt.y    = 32'(cy + scaled(rq.radius, smag, sneg));
                // signed divide truncates toward zero
                pt.z    = 32'(cz + (longint'(rq.hpd) * swept) / 256);
                pt.last = (k + 1 == npts);
                due_points = {due_points, pt};
                if (rq.ccw) angle_now = 16'((ang + hpg_pkg::STEP_CD) % hpg_pkg::FULL_TURN);
                else angle_now = 16'((ang + hpg_pkg::FULL_TURN - hpg_pkg::STEP_CD)
                                     % hpg_pkg::FULL_TURN);
                points_done = 7'(k + 1);
            end
        endfunction

        function void check_point(t_point got);
            t_point want;
            if (due_points.size() == 0) begin
                $error("point word with none due: x %0d y %0d z %0d",
                       $signed(got.x), $signed(got.y), $signed(got.z));
                faults++;
                return;
            end
            want = due_points.pop_front();
            if (got.x !== want.x) begin
                $error("point_x expected %0d actual %0d", $signed(want.x), $signed(got.x));
                faults++;
            end
            if (got.y !== want.y) begin
                $error("point_y expected %0d actual %0d", $signed(want.y), $signed(got.y));
                faults++;
            end
            if (got.z !== want.z) begin
                $error("point_z expected %0d actual %0d", $signed(want.z), $signed(got.z));
                faults++;
            end
            if (got.last !== want.last) begin
                $error("last_point expected %0b actual %0b", want.last, got.last);
                faults++;
            end
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic signed [30:0] i_center_x;
    logic signed [30:0] i_center_y;
    logic signed [30:0] i_center_z;
    logic        [29:0] i_radius;
    logic        [15:0] i_start_angle;
    logic signed [23:0] i_height_per_degree;
    logic        [9:0]  i_total_angle;
    logic               i_counter_clockwise;
    logic               o_strobe;
    logic signed [31:0] o_point_x;
    logic signed [31:0] o_point_y;
    logic signed [31:0] o_point_z;
    logic               o_last_point;

    t_helix_tracker board;
    int unsigned    quiet_cycles;

    helix_point_generator u_top (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .start               (start),
        .busy                (busy),
        .i_center_x          (i_center_x),
        .i_center_y          (i_center_y),
        .i_center_z          (i_center_z),
        .i_radius            (i_radius),
        .i_start_angle       (i_start_angle),
        .i_height_per_degree (i_height_per_degree),
        .i_total_angle       (i_total_angle),
        .i_counter_clockwise (i_counter_clockwise),
        .o_strobe            (o_strobe),
        .o_point_x           (o_point_x),
        .o_point_y           (o_point_y),
        .o_point_z           (o_point_z),
        .o_last_point        (o_last_point)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic t_helix_req make_req(longint cx, longint cy, longint cz,
                                            longint radius, int unsigned sa, longint hpd,
                                            int unsigned total, bit ccw);
        t_helix_req rq;
        rq.cx          = 31'(cx);
        rq.cy          = 31'(cy);
        rq.cz          = 31'(cz);
        rq.radius      = 30'(radius);
        rq.start_angle = 16'(sa);
        rq.hpd         = 24'(hpd);
        rq.total       = 10'(total);
        rq.ccw         = ccw;
        return rq;
    endfunction

    // mostly short helices; a few long and saturated ones
    function automatic t_helix_req random_request();
        t_helix_req  rq;
        int unsigned sel;
        rq.cx  = 31'($urandom());
        rq.cy  = 31'($urandom());
        rq.cz  = 31'($urandom());
        rq.hpd = 24'($urandom());
        rq.ccw = 1'($urandom());
        sel = $urandom_range(99);
        if (sel < 25) rq.radius = 30'($urandom_range(1000));
        else if (sel < 32) rq.radius = (sel < 28) ? 30'd0 : '1;
        else rq.radius = 30'($urandom());
        sel = $urandom_range(99);
        if (sel < 80) rq.start_angle = 16'($urandom_range(35999));
        else if (sel < 90) rq.start_angle = 16'(hpg_pkg::EIGHTH * $urandom_range(7));
        else rq.start_angle = 16'($urandom());
        sel = $urandom_range(99);
        if (sel < 85) rq.total = 10'($urandom_range(60));
        else if (sel < 93) rq.total = 10'($urandom_range(640, 61));
        else rq.total = 10'($urandom_range(1023, 641));
        return rq;
    endfunction

    // holds start high until the word is taken
    task automatic send_request(t_helix_req rq);
        i_center_x          <= rq.cx;
        i_center_y          <= rq.cy;
        i_center_z          <= rq.cz;
        i_radius            <= rq.radius;
        i_start_angle       <= rq.start_angle;
        i_height_per_degree <= rq.hpd;
        i_total_angle       <= rq.total;
        i_counter_clockwise <= rq.ccw;
        start               <= 1'b1;
        do @(posedge i_clk); while (busy);
        board.note_request(rq);
    endtask

    task automatic hold_off(int unsigned cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    // result words cannot be stalled; take each one on its strobe
    always @(posedge i_clk) begin
        t_point got;
        if (i_rst_n && o_strobe) begin
            got.x    = o_point_x;
            got.y    = o_point_y;
            got.z    = o_point_z;
            got.last = o_last_point;
            board.check_point(got);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_strobe) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    initial begin
        t_helix_req directed[$];
        board = new();
        i_rst_n             <= 1'b0;
        start               <= 1'b0;
        i_center_x          <= '0;
        i_center_y          <= '0;
        i_center_z          <= '0;
        i_radius            <= '0;
        i_start_angle       <= '0;
        i_height_per_degree <= '0;
        i_total_angle       <= '0;
        i_counter_clockwise <= 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // field extremes, then angle boundaries and point-count edges
        directed = {directed, make_req(-1073741824, -1073741824, -1073741824, 0, 0,
                                       -8388608, 1, 0)};
        directed = {directed, make_req(1073741823, 1073741823, 1073741823, 1073741823,
                                       35999, 8388607, 640, 1)};
        directed = {directed, make_req(0, 0, 0, 1000, 0, 256, 0, 1)};
        directed = {directed, make_req(0, 0, 0, 1000, 100, 256, 0, 0)};
        directed = {directed, make_req(12345, -6789, 1000, 500000, 0, -1, 1023, 0)};
        directed = {directed, make_req(-1073741824, 1073741823, 0, 1073741823, 36000,
                                       100, 20, 1)};
        directed = {directed, make_req(1073741823, -1073741824, 0, 1073741823, 65535,
                                       -100, 30, 0)};
        directed = {directed, make_req(0, 0, 0, 1073741823, 4500, -300, 9, 1)};
        directed = {directed, make_req(0, 0, 0, 1073741823, 9000, 300, 10, 0)};
        directed = {directed, make_req(0, 0, 0, 1073741823, 13500, -255, 11, 1)};
        directed = {directed, make_req(100, 200, -300, 777777, 18000, 255, 630, 0)};
        directed = {directed, make_req(-100, -200, 300, 777777, 27000, -257, 631, 1)};
        directed = {directed, make_req(0, 0, 0, 1073741823, 4499, 1, 90, 1)};
        directed = {directed, make_req(0, 0, 0, 1073741823, 4501, -1, 90, 0)};
        directed = {directed, make_req(0, 0, 0, 1073741823, 8999, 65536, 120, 1)};
        directed = {directed, make_req(5, -5, 7, 1, 31500, -300, 360, 1)};
        directed = {directed, make_req(0, 0, 0, 536870912, 22500, 4096, 641, 0)};
        directed = {directed, make_req(-1, -1, -1, 65535, 0, -8388608, 700, 1)};
        foreach (directed[i]) send_request(directed[i]);

        for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
            send_request(random_request());
            if (n < RANDOM_ITEMS - CALM_TAIL && $urandom_range(99) < 35)
                hold_off($urandom_range(16, 1));
        end
        start <= 1'b0;

        while (board.due_points.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (board.faults == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule

`default_nettype wire

// File: sim.f
+incdir+hw/rtl
hw/rtl/hpg_pkg.sv
hw/rtl/helix_point_generator.sv
hw/rtl/hpg_checker.sv
tb/helix_point_generator_tb.sv
